@@ hdl/upd_pkg.sv @@
package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam int unsigned NIBBLE_W  = 4;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_in;
    } upd_in_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_out;
        logic       error;
    } upd_out_t;

    // pair: a literal percent goes out first, then ch with last set
    typedef struct packed {
        logic       pair;
        logic [7:0] ch;
        logic       last;
        logic       err;
    } upd_cmd_t;

    typedef enum logic [1:0] {
        PH_PASS  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } upd_phase_t;

    function automatic logic [7:0] plain_map(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    // bit 4 set means not a hex digit
    function automatic logic [NIBBLE_W:0] hex_value(input logic [7:0] c);
        logic [NIBBLE_W:0] v;
        v = 5'h10;
        if (c inside {[8'h30:8'h39]})
        begin
            v = {1'b0, c[3:0]};
        end
        else if (c inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

@@ hdl/upd_front.sv @@
module upd_front
    import upd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  upd_in_t   req_word,
    input  logic      q_full,
    output logic      push,
    output upd_cmd_t  push_word
);

    upd_phase_t phase_reg, phase_next;
    logic [7:0] first_reg, first_next;
    logic       discard_reg, discard_next;
    logic       acc;
    logic [NIBBLE_W:0] hi, lo;

    assign req_stall = q_full;
    assign acc = req_valid && !q_full;
    assign hi = hex_value(first_reg);
    assign lo = hex_value(req_word.char_in);

    always_comb
    begin
        phase_next   = phase_reg;
        first_next   = first_reg;
        discard_next = discard_reg;
        push         = 1'b0;
        push_word    = '0;
        if (acc)
        begin
            if (discard_reg)
            begin
                if (req_word.last_in)
                begin
                    discard_next = 1'b0;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_PCT:
                    begin
                        if (req_word.last_in)
                        begin
                            phase_next     = PH_PASS;
                            push           = 1'b1;
                            push_word.pair = 1'b1;
                            push_word.ch   = plain_map(req_word.char_in);
                            push_word.last = 1'b1;
                        end
                        else
                        begin
                            first_next = req_word.char_in;
                            phase_next = PH_DIGIT;
                        end
                    end
                    PH_DIGIT:
                    begin
                        phase_next = PH_PASS;
                        push       = 1'b1;
                        if (hi[NIBBLE_W] || lo[NIBBLE_W])
                        begin
                            push_word.err  = 1'b1;
                            push_word.last = 1'b1;
                            discard_next   = !req_word.last_in;
                        end
                        else
                        begin
                            push_word.ch   = {hi[NIBBLE_W-1:0], lo[NIBBLE_W-1:0]};
                            push_word.last = req_word.last_in;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_PASS;
                        if (req_word.char_in == CH_PERCENT)
                        begin
                            if (req_word.last_in)
                            begin
                                push           = 1'b1;
                                push_word.ch   = CH_PERCENT;
                                push_word.last = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PCT;
                            end
                        end
                        else
                        begin
                            push           = 1'b1;
                            push_word.ch   = plain_map(req_word.char_in);
                            push_word.last = req_word.last_in;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_PASS;
            discard_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            discard_reg <= discard_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
    end

endmodule

@@ hdl/upd_queue.sv @@
module upd_queue
    import upd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  upd_cmd_t push_word,
    output logic     full,
    output logic     q_valid,
    output upd_cmd_t q_word,
    input  logic     pop
);

    upd_cmd_t   mem_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_word  = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_word;
        end
    end

endmodule

@@ hdl/upd_back.sv @@
module upd_back
    import upd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    input  upd_cmd_t q_word,
    output logic     pop,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output upd_out_t rsp_word
);

    logic       valid_reg;
    upd_out_t   out_reg;
    logic       pend_reg;
    logic [7:0] pend_ch_reg;
    logic       load;

    assign load      = !valid_reg || !rsp_stall;
    assign pop       = load && !pend_reg && q_valid;
    assign rsp_valid = valid_reg;
    assign rsp_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else
            begin
                valid_reg <= q_valid;
                pend_reg  <= q_valid && q_word.pair;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg)
            begin
                out_reg <= '{char_out: pend_ch_reg, last_out: 1'b1, error: 1'b0};
            end
            else if (q_word.pair)
            begin
                out_reg     <= '{char_out: CH_PERCENT, last_out: 1'b0, error: 1'b0};
                pend_ch_reg <= q_word.ch;
            end
            else
            begin
                out_reg <= '{char_out: q_word.ch, last_out: q_word.last, error: q_word.err};
            end
        end
    end

endmodule

@@ hdl/url_percent_decoder_core.sv @@
// path: each result passes through the two-entry queue, then the output register
// throughput: one word per cycle unless req_stall is high; a lone percent before
// a final byte sends two result words, the second after the first is taken
// reset: rst_n clears the decode phase, the drop flag, the queue and output valid
module url_percent_decoder_core
    import upd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  upd_in_t  req_word,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output upd_out_t rsp_word
);

    logic     q_full, push, q_valid, pop;
    upd_cmd_t push_word, q_word;

    upd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .q_full    (q_full),
        .push      (push),
        .push_word (push_word)
    );

    upd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .pop       (pop)
    );

    upd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

endmodule

@@ test/url_percent_decoder_core_tb.sv @@
`timescale 1ns / 100ps

module url_percent_decoder_core_tb;
    import upd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS    = 25;
    localparam int PHASE_WORDS = 430;

    typedef struct packed {
        logic       typed;
        logic [1:0] n;
        upd_in_t    w;
        upd_out_t   e0;
        upd_out_t   e1;
    } dir_row_t;

    localparam upd_out_t NO_OUT  = '0;
    localparam upd_out_t ERR_OUT = '{8'h00, 1'b1, 1'b1};

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    upd_in_t  req_word  = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    upd_out_t rsp_word;

    upd_out_t   pending_out[$];
    dir_row_t   dir_tab [0:DIR_ROWS-1];
    upd_phase_t ph       = PH_PASS;
    logic [7:0] held     = 8'h00;
    logic       dropping = 1'b0;

    int send_idle   = 0;
    int rcv_idle    = 0;
    int fail_count  = 0;
    int words_sent  = 0;
    int words_seen  = 0;
    int errors_seen = 0;
    int cycles      = 0;

    url_percent_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected", cycles,
                     pending_out.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b0, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = {1'b0, 4'(c - 8'h41 + 8'd10)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = {1'b0, 4'(c - 8'h61 + 8'd10)};
        end
        return v;
    endfunction

    function automatic logic [7:0] space_for_plus(input logic [7:0] c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    task automatic decode_byte(input upd_in_t w, output int n, output upd_out_t r0,
                               output upd_out_t r1);
        logic [4:0] hi;
        logic [4:0] lo;
        n  = 0;
        r0 = NO_OUT;
        r1 = NO_OUT;
        if (dropping)
        begin
            if (w.last_in)
            begin
                dropping = 1'b0;
            end
        end
        else
        begin
            case (ph)
                PH_PCT:
                begin
                    if (w.last_in)
                    begin
                        ph = PH_PASS;
                        r0 = '{CH_PERCENT, 1'b0, 1'b0};
                        r1 = '{space_for_plus(w.char_in), 1'b1, 1'b0};
                        n  = 2;
                    end
                    else
                    begin
                        held = w.char_in;
                        ph   = PH_DIGIT;
                    end
                end
                PH_DIGIT:
                begin
                    hi   = nibble_of(held);
                    lo   = nibble_of(w.char_in);
                    ph   = PH_PASS;
                    held = 8'h00;
                    n    = 1;
                    if (hi[4] || lo[4])
                    begin
                        r0       = ERR_OUT;
                        dropping = !w.last_in;
                    end
                    else
                    begin
                        r0 = '{{hi[3:0], lo[3:0]}, w.last_in, 1'b0};
                    end
                end
                default:
                begin
                    ph = PH_PASS;
                    if (w.char_in == CH_PERCENT && !w.last_in)
                    begin
                        ph = PH_PCT;
                    end
                    else
                    begin
                        r0 = '{space_for_plus(w.char_in), w.last_in, 1'b0};
                        n  = 1;
                    end
                end
            endcase
        end
    endtask

    // one word through the request channel, expectations queued at acceptance
    task automatic send_word(input upd_in_t w, input logic typed, input int tn,
                             input upd_out_t t0, input upd_out_t t1);
        int       n;
        upd_out_t r0;
        upd_out_t r1;
        while ($urandom_range(0, 99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        words_sent++;
        decode_byte(w, n, r0, r1);
        if (typed)
        begin
            n  = tn;
            r0 = t0;
            r1 = t1;
        end
        if (n > 0)
        begin
            pending_out.push_back(r0);
        end
        if (n > 1)
        begin
            pending_out.push_back(r1);
        end
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_out.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
        begin
            return 8'h30 + 8'(r);
        end
        else if (r < 16)
        begin
            return 8'h61 + 8'(r - 10);
        end
        return 8'h41 + 8'(r - 16);
    endfunction

    task automatic send_string();
        logic [7:0] str_q[$];
        upd_in_t    w;
        int         len;
        int         r;
        len = $urandom_range(1, 10);
        while (str_q.size() < len)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                str_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
            end
            else if (r < 45)
            begin
                str_q.push_back(CH_PLUS);
            end
            else if (r < 70)
            begin
                str_q.push_back(CH_PERCENT);
                str_q.push_back(hex_char());
                str_q.push_back(hex_char());
            end
            else if (r < 80)
            begin
                str_q.push_back(8'($urandom_range(0, 255)));
            end
            else if (r < 90)
            begin
                str_q.push_back(CH_PERCENT);
                str_q.push_back($urandom_range(0, 1) ? hex_char() : 8'($urandom_range(0, 255)));
                str_q.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                str_q.push_back(CH_PERCENT);
                str_q.push_back(hex_char());
            end
        end
        foreach (str_q[i])
        begin
            w.char_in = str_q[i];
            w.last_in = (i == str_q.size() - 1);
            send_word(w, 1'b0, 0, NO_OUT, NO_OUT);
        end
    endtask

    always @(posedge clk)
    begin
        upd_out_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            words_seen++;
            if (rsp_word.error)
            begin
                errors_seen++;
            end
            if (pending_out.size() == 0)
            begin
                $display("%0t unexpected word: expected none, actual %h/%b/%b", $time,
                         rsp_word.char_out, rsp_word.last_out, rsp_word.error);
                fail_count++;
            end
            else
            begin
                e = pending_out.pop_front();
                if (rsp_word.char_out !== e.char_out)
                begin
                    $display("%0t char_out: expected %h, actual %h", $time, e.char_out,
                             rsp_word.char_out);
                    fail_count++;
                end
                if (rsp_word.last_out !== e.last_out)
                begin
                    $display("%0t last_out: expected %b, actual %b", $time, e.last_out,
                             rsp_word.last_out);
                    fail_count++;
                end
                if (rsp_word.error !== e.error)
                begin
                    $display("%0t error: expected %b, actual %b", $time, e.error,
                             rsp_word.error);
                    fail_count++;
                end
            end
        end
        rsp_stall <= ($urandom_range(0, 99) < rcv_idle);
    end

    initial
    begin
        int   start_count;
        logic paused;
        dir_tab = '{
            '{1'b1, 2'd1, '{8'h61, 1'b0}, '{8'h61, 1'b0, 1'b0}, NO_OUT},
            '{1'b1, 2'd1, '{8'h2B, 1'b0}, '{8'h20, 1'b0, 1'b0}, NO_OUT},
            '{1'b1, 2'd1, '{8'h00, 1'b0}, '{8'h00, 1'b0, 1'b0}, NO_OUT},
            '{1'b1, 2'd1, '{8'hFF, 1'b1}, '{8'hFF, 1'b1, 1'b0}, NO_OUT},
            // percent as final byte
            '{1'b1, 2'd1, '{8'h25, 1'b1}, '{8'h25, 1'b1, 1'b0}, NO_OUT},
            // percent, then a final plus
            '{1'b1, 2'd0, '{8'h25, 1'b0}, NO_OUT, NO_OUT},
            '{1'b1, 2'd2, '{8'h2B, 1'b1}, '{8'h25, 1'b0, 1'b0}, '{8'h20, 1'b1, 1'b0}},
            '{1'b1, 2'd0, '{8'h25, 1'b0}, NO_OUT, NO_OUT},
            '{1'b1, 2'd0, '{8'h34, 1'b0}, NO_OUT, NO_OUT},
            '{1'b0, 2'd0, '{8'h31, 1'b1}, NO_OUT, NO_OUT},
            // mixed case digits, not final
            '{1'b1, 2'd0, '{8'h25, 1'b0}, NO_OUT, NO_OUT},
            '{1'b1, 2'd0, '{8'h66, 1'b0}, NO_OUT, NO_OUT},
            '{1'b0, 2'd0, '{8'h46, 1'b0}, NO_OUT, NO_OUT},
            '{1'b0, 2'd0, '{8'h7A, 1'b1}, NO_OUT, NO_OUT},
            // bad second digit, rest of string dropped
            '{1'b1, 2'd0, '{8'h25, 1'b0}, NO_OUT, NO_OUT},
            '{1'b1, 2'd0, '{8'h31, 1'b0}, NO_OUT, NO_OUT},
            '{1'b1, 2'd1, '{8'h67, 1'b0}, ERR_OUT, NO_OUT},
            '{1'b1, 2'd0, '{8'h78, 1'b0}, NO_OUT, NO_OUT},
            '{1'b1, 2'd0, '{8'h79, 1'b1}, NO_OUT, NO_OUT},
            // high byte as first digit, error on the final byte
            '{1'b1, 2'd0, '{8'h25, 1'b0}, NO_OUT, NO_OUT},
            '{1'b1, 2'd0, '{8'h80, 1'b0}, NO_OUT, NO_OUT},
            '{1'b1, 2'd1, '{8'h31, 1'b1}, ERR_OUT, NO_OUT},
            '{1'b0, 2'd0, '{8'h71, 1'b1}, NO_OUT, NO_OUT},
            '{1'b1, 2'd0, '{8'h25, 1'b0}, NO_OUT, NO_OUT},
            '{1'b1, 2'd2, '{8'h41, 1'b1}, '{8'h25, 1'b0, 1'b0}, '{8'h41, 1'b1, 1'b0}}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 3; p++)
        begin
            send_idle = (p == 0) ? 31 : (p == 1) ? 69 : 0;
            rcv_idle  = (p == 0) ? 69 : (p == 1) ? 31 : 0;
            if (p == 0)
            begin
                for (int i = 0; i < DIR_ROWS; i++)
                begin
                    send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].n,
                              dir_tab[i].e0, dir_tab[i].e1);
                end
            end
            start_count = words_sent;
            paused      = 1'b0;
            while (words_sent - start_count < PHASE_WORDS)
            begin
                send_string();
                if (!paused && words_sent - start_count >= PHASE_WORDS / 2)
                begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (pending_out.size() != 0)
        begin
            $display("%0t %0d expected words never arrived", $time, pending_out.size());
            fail_count++;
        end
        $display("sent %0d encoded bytes over three stall mixes, checked %0d decoded words",
                 words_sent, words_seen);
        $display("of those, %0d were bad percent sequences", errors_seen);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/upd_pkg.sv
hdl/upd_front.sv
hdl/upd_queue.sv
hdl/upd_back.sv
hdl/url_percent_decoder_core.sv
test/url_percent_decoder_core_tb.sv
